FILE: rtl/srwc_pkg.sv
`timescale 1ns / 1ps
// Package for the sequence replay window checker.
// Holds the verdict codes and the history record type; no dependencies.
package srwc_pkg;

   localparam int unsigned SEQ_W  = 32;
   localparam int unsigned TICK_W = 32;

   typedef enum logic [2:0] {
      VERDICT_ACCEPTED  = 3'd0,
      VERDICT_DUPLICATE = 3'd1,
      VERDICT_TOO_OLD   = 3'd2,
      VERDICT_TOO_NEW   = 3'd3,
      VERDICT_INVALID   = 3'd4
   } verdict_type;

   // One ring entry: the accepted sequence and its arrival tick
   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [TICK_W-1:0] tick;
   } hist_rec_type;

endpackage

FILE: rtl/sequence_replay_window_checker.sv
`timescale 1ns / 1ps
// Sequence replay window checker: classifies commands against the highest
// accepted sequence and keeps a history ring. Depends on srwc_pkg.
//
// Pipeline: the word for a command passes the stage-1 register (with the
//   registered ring read) and the output register before it is on rsp_*.
// Throughput: one command per cycle; busy stays low. The single ring memory
//   (one write port, one read port) sets this figure.
// Reset: synchronous, active high; clears top sequence, write slot,
//   owned entity, the stage-1 valid and the response strobe. Ring contents are never read
//   before written, so no clearing pass is run. The receiver cannot stall.
module sequence_replay_window_checker #(
   parameter int unsigned WINDOW_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_cmd_seq,
   input  logic [31:0] req_cmd_entity,
   input  logic [31:0] req_now_tick,
   // configuration
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   // response channel
   output logic        rsp_valid,
   output logic [31:0] rsp_out_seq,
   output logic [31:0] rsp_out_tick,
   output logic [2:0]  rsp_verdict,
   output logic        rsp_apply_now
);

   localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned CALC_W = SLOT_W + 2;

   // ------------------------------------------------------------------
   // State registers
   // ------------------------------------------------------------------
   logic [31:0]       owned_ff;
   logic [31:0]       top_ff,     top_in;
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;

   // History ring: one write port, one registered read port
   srwc_pkg::hist_rec_type hist_mem [WINDOW_DEPTH];
   srwc_pkg::hist_rec_type rd_rec_ff;

   // Stage 1: command waiting on the ring read
   logic                  s1_valid_ff,   s1_valid_in;
   logic [31:0]           s1_seq_ff,     s1_seq_in;
   logic [31:0]           s1_tick_ff,    s1_tick_in;
   srwc_pkg::verdict_type s1_verdict_ff, s1_verdict_in;
   logic                  s1_apply_ff,   s1_apply_in;
   logic                  s1_lookup_ff,  s1_lookup_in;

   // Output register
   logic                  rsp_valid_ff,   rsp_valid_in;
   logic [31:0]           rsp_seq_ff,     rsp_seq_in;
   logic [31:0]           rsp_tick_ff,    rsp_tick_in;
   srwc_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic                  rsp_apply_ff,   rsp_apply_in;

   // ------------------------------------------------------------------
   // Classification of the incoming command
   // ------------------------------------------------------------------
   logic              take;
   logic              bad_entity;
   logic [32:0]       top_plus1;
   logic [31:0]       lag;
   logic              in_window;
   logic [SLOT_W-1:0] lag_lo;
   logic [CALC_W-1:0] slot_raw;
   logic [SLOT_W-1:0] rd_slot;
   logic              accept;

   // Every cycle is free: one command enters per clock
   assign busy = 1'b0;
   assign take = start && !busy;

   assign bad_entity = (owned_ff == 32'd0) || (req_cmd_entity != owned_ff);
   assign top_plus1  = {1'b0, top_ff} + 33'd1;
   assign lag        = top_ff - req_cmd_seq;
   assign in_window  = (lag < 32'(WINDOW_DEPTH));
   assign lag_lo     = lag[SLOT_W-1:0];

   // Slot of an in-window sequence: step back (lag + 1) from the write slot.
   // The write slot always equals top_ff mod depth, so this matches (seq - 1) mod depth.
   always_comb begin
      slot_raw = {2'b00, wr_slot_ff} - CALC_W'(1) - {2'b00, lag_lo};
      if (slot_raw[CALC_W-1]) begin
         slot_raw = slot_raw + CALC_W'(WINDOW_DEPTH);
      end
      rd_slot = slot_raw[SLOT_W-1:0];
   end

   always_comb begin
      s1_verdict_in = srwc_pkg::VERDICT_ACCEPTED;
      s1_lookup_in  = 1'b0;
      accept        = 1'b0;
      if (bad_entity) begin
         s1_verdict_in = srwc_pkg::VERDICT_INVALID;
      end else if (top_ff == 32'd0) begin
         // nothing accepted yet: only sequence one opens the stream
         if (req_cmd_seq == 32'd1) begin
            accept = 1'b1;
         end else begin
            s1_verdict_in = srwc_pkg::VERDICT_TOO_NEW;
         end
      end else if (req_cmd_seq <= top_ff) begin
         if (!in_window) begin
            s1_verdict_in = srwc_pkg::VERDICT_TOO_OLD;
         end else begin
            // sequence zero is never in the ring: plain duplicate
            s1_verdict_in = srwc_pkg::VERDICT_DUPLICATE;
            s1_lookup_in  = (req_cmd_seq != 32'd0);
         end
      end else if ({1'b0, req_cmd_seq} != top_plus1) begin
         s1_verdict_in = srwc_pkg::VERDICT_TOO_NEW;
      end else begin
         accept = 1'b1;
      end
   end

   assign s1_valid_in = take;
   assign s1_seq_in   = req_cmd_seq;
   assign s1_tick_in  = req_now_tick;
   assign s1_apply_in = accept;

   // Advance top and the write slot on every newly accepted command
   always_comb begin
      top_in     = top_ff;
      wr_slot_in = wr_slot_ff;
      if (take && accept) begin
         top_in = req_cmd_seq;
         if (wr_slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) begin
            wr_slot_in = '0;
         end else begin
            wr_slot_in = wr_slot_ff + SLOT_W'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Ring memory. A read only targets a sequence at or below top, while a
   // write only stores top + 1, so one command never reads what it writes;
   // a write lands at the edge before any later read of that slot.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (take && accept) begin
         hist_mem[wr_slot_ff] <= '{seq: req_cmd_seq, tick: req_now_tick};
      end
      if (take && s1_lookup_in) begin
         rd_rec_ff <= hist_mem[rd_slot];
      end
   end

   // ------------------------------------------------------------------
   // Stage 1 to output: replace a found duplicate with its stored record
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in   = s1_valid_ff;
      rsp_seq_in     = s1_seq_ff;
      rsp_tick_in    = s1_tick_ff;
      rsp_verdict_in = s1_verdict_ff;
      rsp_apply_in   = s1_apply_ff;
      if (s1_lookup_ff && (rd_rec_ff.seq == s1_seq_ff)) begin
         rsp_seq_in     = rd_rec_ff.seq;
         rsp_tick_in    = rd_rec_ff.tick;
         rsp_verdict_in = srwc_pkg::VERDICT_ACCEPTED;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         owned_ff     <= 32'd0;
         top_ff       <= 32'd0;
         wr_slot_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            owned_ff <= csr_wr_data;
         end
         top_ff       <= top_in;
         wr_slot_ff   <= wr_slot_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      s1_seq_ff      <= s1_seq_in;
      s1_tick_ff     <= s1_tick_in;
      s1_verdict_ff  <= s1_verdict_in;
      s1_apply_ff    <= s1_apply_in;
      s1_lookup_ff   <= s1_lookup_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_tick_ff    <= rsp_tick_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_apply_ff   <= rsp_apply_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_seq   = rsp_seq_ff;
   assign rsp_out_tick  = rsp_tick_ff;
   assign rsp_verdict   = rsp_verdict_ff;
   assign rsp_apply_now = rsp_apply_ff;

endmodule

FILE: verif/tb_sequence_replay_window_checker.sv
`timescale 1ns / 1ps
// Self-checking testbench for sequence_replay_window_checker.
// Drives commands and owner writes, predicts each response word in a scoreboard
// class, and compares field by field. Depends on srwc_pkg and the RTL only.

// Scoreboard: tracks the owned entity, the highest accepted sequence and the
// history ring, and queues one expected response word per taken command.
class verdict_scoreboard #(int unsigned DEPTH = 64);

   typedef struct {
      logic [srwc_pkg::SEQ_W-1:0]  seq;
      logic [srwc_pkg::TICK_W-1:0] tick;
      srwc_pkg::verdict_type       verdict;
      logic                        apply_now;
   } verdict_word_type;

   logic [31:0]                 owned_entity;
   logic [srwc_pkg::SEQ_W-1:0]  top_seq;
   logic [31:0]                 write_slot;
   logic [srwc_pkg::SEQ_W-1:0]  ring_seq [DEPTH];
   logic [srwc_pkg::TICK_W-1:0] ring_tick [DEPTH];
   verdict_word_type            expected_words [$];
   int unsigned                 error_count;
   int unsigned                 command_count;
   int unsigned                 replay_count;
   int unsigned                 verdict_count [5];

   function new();
      owned_entity  = '0;
      top_seq       = '0;
      write_slot    = '0;
      error_count   = 0;
      command_count = 0;
      replay_count  = 0;
      foreach (ring_seq[i]) begin
         ring_seq[i]  = '0;
         ring_tick[i] = '0;
      end
      foreach (verdict_count[i]) verdict_count[i] = 0;
   endfunction

   task report_mismatch(input string what);
      error_count++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // Return the stored record for a replayed sequence, or a plain duplicate.
   function verdict_word_type replay_lookup(logic [srwc_pkg::SEQ_W-1:0] seq,
                                            logic [srwc_pkg::TICK_W-1:0] tick);
      verdict_word_type           w;
      logic [srwc_pkg::SEQ_W-1:0] oldest;
      int unsigned                slot;
      w      = '{seq, tick, srwc_pkg::VERDICT_DUPLICATE, 1'b0};
      oldest = (top_seq >= DEPTH) ? top_seq - DEPTH + 32'd1 : 32'd1;
      slot   = (seq - 32'd1) % DEPTH;
      if (seq != '0 && seq >= oldest && ring_seq[slot] == seq) begin
         w = '{ring_seq[slot], ring_tick[slot], srwc_pkg::VERDICT_ACCEPTED, 1'b0};
      end
      return w;
   endfunction

   // Classify one command and update the window state on an accept.
   function verdict_word_type classify(logic [srwc_pkg::SEQ_W-1:0] seq, logic [31:0] ent,
                                       logic [srwc_pkg::TICK_W-1:0] tick);
      verdict_word_type w;
      logic             take;
      int unsigned      slot;
      take = 1'b0;
      w    = '{seq, tick, srwc_pkg::VERDICT_INVALID, 1'b0};
      if (owned_entity == '0 || ent != owned_entity) begin
         w.verdict = srwc_pkg::VERDICT_INVALID;
      end else if (top_seq == '0) begin
         if (seq == 32'd1) take = 1'b1;
         else w.verdict = srwc_pkg::VERDICT_TOO_NEW;
      end else if (seq <= top_seq) begin
         if (top_seq - seq >= DEPTH) w.verdict = srwc_pkg::VERDICT_TOO_OLD;
         else w = replay_lookup(seq, tick);
      end else if ({1'b0, seq} > {1'b0, top_seq} + 33'd1) begin
         w.verdict = srwc_pkg::VERDICT_TOO_NEW;
      end else begin
         take = 1'b1;
      end
      if (take) begin
         top_seq         = seq;
         slot            = write_slot % DEPTH;
         ring_seq[slot]  = seq;
         ring_tick[slot] = tick;
         write_slot      = write_slot + 32'd1;
         w = '{seq, tick, srwc_pkg::VERDICT_ACCEPTED, 1'b1};
      end
      return w;
   endfunction

   task note_command(input logic [31:0] seq, ent, tick);
      verdict_word_type w;
      w = classify(seq, ent, tick);
      command_count++;
      verdict_count[w.verdict]++;
      if (w.verdict == srwc_pkg::VERDICT_ACCEPTED && !w.apply_now) replay_count++;
      expected_words = {expected_words, w};
   endtask

   task check_word(input logic [31:0] seq, tick, input logic [2:0] verdict,
                   input logic apply_now);
      verdict_word_type w;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("response word with no command pending (seq %0d)", seq));
         return;
      end
      w = expected_words.pop_front();
      if (seq !== w.seq)
         report_mismatch($sformatf("out_seq %h, expected %h", seq, w.seq));
      if (tick !== w.tick)
         report_mismatch($sformatf("seq %0d: out_tick %h, expected %h", w.seq, tick, w.tick));
      if (verdict !== w.verdict)
         report_mismatch($sformatf("seq %0d: verdict %0d, expected %s",
                                   w.seq, verdict, w.verdict.name()));
      if (apply_now !== w.apply_now)
         report_mismatch($sformatf("seq %0d: apply_now %b, expected %b",
                                   w.seq, apply_now, w.apply_now));
   endtask

   task finish_check();
      verdict_word_type w;
      while (expected_words.size() != 0) begin
         w = expected_words.pop_front();
         report_mismatch($sformatf("command seq %0d never answered", w.seq));
      end
   endtask

endclass

module tb_sequence_replay_window_checker;

   localparam int unsigned WINDOW_DEPTH = 64;
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
   localparam logic [31:0] TOP_BIT      = 32'h8000_0000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic        busy;
   logic [31:0] req_cmd_seq    = '0;
   logic [31:0] req_cmd_entity = '0;
   logic [31:0] req_now_tick   = '0;
   logic        csr_wr_en      = 1'b0;
   logic [31:0] csr_wr_data    = '0;
   logic        rsp_valid;
   logic [31:0] rsp_out_seq;
   logic [31:0] rsp_out_tick;
   logic [2:0]  rsp_verdict;
   logic        rsp_apply_now;

   verdict_scoreboard #(WINDOW_DEPTH) sb;

   sequence_replay_window_checker #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd_seq   (req_cmd_seq),
      .req_cmd_entity(req_cmd_entity),
      .req_now_tick  (req_now_tick),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_out_seq   (rsp_out_seq),
      .rsp_out_tick  (rsp_out_tick),
      .rsp_verdict   (rsp_verdict),
      .rsp_apply_now (rsp_apply_now)
   );

   always #10 clock = ~clock;

   // Sample both channels on the edge that accepts them. Check the response
   // first: its expectation was queued when its command was taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid !== 1'b0)
            sb.check_word(rsp_out_seq, rsp_out_tick, rsp_verdict, rsp_apply_now);
         if (start === 1'b1 && busy === 1'b0)
            sb.note_command(req_cmd_seq, req_cmd_entity, req_now_tick);
      end
   end

   // Present one command word and hold it until the edge that takes it.
   // Leave start high so the next word can follow back to back.
   task send_command(input logic [31:0] seq, ent, tick);
      start          <= 1'b1;
      req_cmd_seq    <= seq;
      req_cmd_entity <= ent;
      req_now_tick   <= tick;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Drop start for an idle burst of random length.
   task idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clock);
   endtask

   // Drain all outstanding words, then write the owned entity.
   task write_owner(input logic [31:0] owner);
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_words.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= owner;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      sb.owned_entity = owner;
   endtask

   // Mostly well-formed traffic around the current top sequence: next in
   // line, replays inside the window, both window edges, and some noise.
   task random_phase(input int unsigned count, input logic [31:0] owner,
                     input int unsigned idle_pct);
      logic [31:0] seq;
      logic [31:0] ent;
      logic [31:0] top;
      int unsigned pick;
      write_owner(owner);
      // advance a local copy of the top so choices never race the monitor
      top = sb.top_seq;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      seq = top + 32'd1;
         else if (pick < 63) seq = top - $urandom_range(0, WINDOW_DEPTH - 1);
         else if (pick < 68) seq = top - (WINDOW_DEPTH - 1);
         else if (pick < 73) seq = top - WINDOW_DEPTH;
         else if (pick < 78) seq = top - $urandom_range(WINDOW_DEPTH + 1, 5000);
         else if (pick < 83) seq = '0;
         else if (pick < 91) seq = top + $urandom_range(2, 12);
         else                seq = $urandom();
         ent = owner;
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0) ent = owner ^ (32'd1 << $urandom_range(0, 31));
            else ent = $urandom();
         end
         if (owner != '0 && ent == owner && seq == top + 32'd1) top = seq;
         send_command(seq, ent, $urandom());
         if ($urandom_range(0, 99) < idle_pct) idle_burst();
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Owner still zero from reset: reject everything, entity zero included.
      send_command(32'd1, 32'd0, 32'd0);
      send_command(32'd1, 32'd1, 32'h0000_1234);

      write_owner(ALL_ONES);
      // Before any accept only sequence 1 gets in.
      send_command(32'd0, ALL_ONES, 32'd7);
      send_command(32'd2, ALL_ONES, 32'd8);
      send_command(32'd1, ALL_ONES - 32'd1, 32'd9);
      send_command(32'd1, ALL_ONES, ALL_ONES);
      // Replay of the top: stored record comes back with its original tick.
      send_command(32'd1, ALL_ONES, 32'd0);
      // Sequence zero is never in the ring.
      send_command(32'd0, ALL_ONES, 32'd11);
      send_command(32'd3, ALL_ONES, 32'd12);
      send_command(ALL_ONES, ALL_ONES, 32'd13);
      send_command(32'd2, ALL_ONES, 32'd0);
      // Back-to-back replay of the word just written.
      send_command(32'd2, ALL_ONES, 32'd15);
      send_command(32'd3, ALL_ONES, TOP_BIT);
      send_command(32'd3, ALL_ONES, 32'd17);
      send_command(32'd1, ALL_ONES, 32'd18);

      // Window state survives an owner change.
      write_owner(32'd1);
      send_command(32'd4, 32'd1, 32'hA5A5_A5A5);
      send_command(32'd4, ALL_ONES, 32'd20);
      send_command(32'd5, 32'd1, 32'h5A5A_5A5A);
      idle_burst();
      send_command(32'd5, 32'd1, 32'd22);

      random_phase(350, $urandom() | 32'd1, 15);
      random_phase(300, 32'd1, 20);
      random_phase(300, ALL_ONES, 10);
      random_phase(60, 32'd0, 15);
      random_phase(300, TOP_BIT, 15);
      // Final stretch runs at full rate.
      random_phase(290, $urandom() | TOP_BIT, 0);

      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_words.size() != 0) @(posedge clock);
      // Wait on for any stray word past the pipeline depth.
      repeat (8) @(posedge clock);
      sb.finish_check();

      $display("Ran %0d commands over six owner settings; %0d fresh accepts, %0d replays",
               sb.command_count,
               sb.verdict_count[srwc_pkg::VERDICT_ACCEPTED] - sb.replay_count,
               sb.replay_count);
      $display("  from history, %0d duplicates, %0d too old, %0d too new, %0d wrong entity",
               sb.verdict_count[srwc_pkg::VERDICT_DUPLICATE],
               sb.verdict_count[srwc_pkg::VERDICT_TOO_OLD],
               sb.verdict_count[srwc_pkg::VERDICT_TOO_NEW],
               sb.verdict_count[srwc_pkg::VERDICT_INVALID]);
      if (sb.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: several times what a correct run needs even with the longest idles.
   initial begin
      #5_000_000;
      $display("Timeout: simulation did not drain");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
